FILE: rtl/spq_pkg.sv
// ============================================================================
// spq_pkg
// Shared types and codes for the stable sorted priority queue: request and
// result payloads, command codes and result status codes.
// ============================================================================
package spq_pkg;

    // Command codes
    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    // Result status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    // Request payload
    typedef struct packed {
        logic        command;
        logic [15:0] entry_tag;
        logic [7:0]  entry_age;
        logic [7:0]  entry_priority;
    } t_in;

    // Result payload
    typedef struct packed {
        t_status     status;
        logic        out_valid;
        logic [15:0] out_tag;
        logic [7:0]  out_age;
        logic [7:0]  out_priority;
        logic [4:0]  fill_level;
    } t_out;

endpackage

FILE: rtl/stable_priority_queue_top.sv
// ============================================================================
// stable_priority_queue_top
// Bounded priority queue kept sorted in a single-port-write circular memory.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one request:
//   enqueue an entry or dequeue the front entry. Every request gives exactly
//   one result on the output channel (o_out_valid / i_out_ready / o_out_data)
//   with a status: ok, empty (dequeue with nothing held) or full (enqueue
//   dropped). Smaller priority leaves first; equal priorities keep arrival
//   order.
//   Entries live in a circular memory with a head pointer, so a dequeue is a
//   single read. An enqueue walks from the tail toward the head, reading one
//   entry and writing it one slot back each cycle until the insert point.
//   A new request is accepted only once the last one has left the sequencer;
//   an enqueue also shifts each held entry with a larger priority, one per
//   cycle through the memory's read port.
//   Results sit in an output register; the block accepts the next request
//   while a result waits there. If the receiver stalls with a result still
//   waiting, the next result holds in the block and no request is accepted.
//   Reset empties the queue; memory contents are not cleared (entries are
//   only read after they are written).
// ============================================================================
module stable_priority_queue_top #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int TAG_BITS      = 16,
    parameter int PRIORITY_BITS = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  spq_pkg::t_in i_in_data,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output spq_pkg::t_out o_out_data
);
    import spq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int TW = (TAG_BITS < 16) ? TAG_BITS : 16;
    localparam int PW = (PRIORITY_BITS < 8) ? PRIORITY_BITS : 8;

    typedef struct packed {
        logic [TW-1:0] tag;
        logic [7:0]    age;
        logic [PW-1:0] prio;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENQ_CMP,
        S_ENQ_PUT,
        S_DEQ_WAIT,
        S_RESULT
    } t_state;

    // Logical queue position to physical memory address
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] pos);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(pos);
        if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
            sum = sum - (CW+1)'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    t_state        r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    t_entry        r_new, n_new;
    t_out          r_res, n_res;
    logic          r_out_valid, n_out_valid;
    t_out          r_out, n_out;

    // Memory port signals
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    t_entry        r_rdata;
    t_entry        mem [QUEUE_DEPTH];

    logic accept;
    logic out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Entry memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    // Sequencer and memory control
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_idx       = r_idx;
        n_new       = r_new;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_waddr   = phys(r_head, r_idx);
        mem_wdata   = r_new;
        mem_re      = 1'b0;
        mem_raddr   = r_head;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_new.tag  = TW'(i_in_data.entry_tag);
                    n_new.age  = i_in_data.entry_age;
                    n_new.prio = PW'(i_in_data.entry_priority);
                    n_res      = '0;
                    if (i_in_data.command == CMD_DEQ) begin
                        if (r_count == '0) begin
                            n_res.status = ST_EMPTY;
                            n_state      = S_RESULT;
                        end else begin
                            mem_re    = 1'b1;
                            mem_raddr = r_head;
                            n_state   = S_DEQ_WAIT;
                        end
                    end else if (r_count == CW'(QUEUE_DEPTH)) begin
                        n_res.status     = ST_FULL;
                        n_res.fill_level = 5'(r_count);
                        n_state          = S_RESULT;
                    end else if (r_count == '0) begin
                        n_idx   = '0;
                        n_state = S_ENQ_PUT;
                    end else begin
                        // Start at the tail: compare with the last entry
                        n_idx     = r_count;
                        mem_re    = 1'b1;
                        mem_raddr = phys(r_head, r_count - 1'b1);
                        n_state   = S_ENQ_CMP;
                    end
                end
            end

            S_ENQ_CMP: begin
                mem_we    = 1'b1;
                mem_waddr = phys(r_head, r_idx);
                if (r_rdata.prio > r_new.prio) begin
                    // Larger priority moves one slot back
                    mem_wdata = r_rdata;
                    n_idx     = r_idx - 1'b1;
                    if (r_idx == CW'(1)) begin
                        n_state = S_ENQ_PUT;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = phys(r_head, r_idx - CW'(2));
                    end
                end else begin
                    // Insert point found
                    mem_wdata        = r_new;
                    n_count          = r_count + 1'b1;
                    n_res.status     = ST_OK;
                    n_res.fill_level = 5'(n_count);
                    n_state          = S_RESULT;
                end
            end

            S_ENQ_PUT: begin
                mem_we           = 1'b1;
                mem_waddr        = phys(r_head, r_idx);
                mem_wdata        = r_new;
                n_count          = r_count + 1'b1;
                n_res.status     = ST_OK;
                n_res.fill_level = 5'(n_count);
                n_state          = S_RESULT;
            end

            S_DEQ_WAIT: begin
                n_count            = r_count - 1'b1;
                n_head             = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                n_res.status       = ST_OK;
                n_res.out_valid    = 1'b1;
                n_res.out_tag      = 16'(r_rdata.tag);
                n_res.out_age      = r_rdata.age;
                n_res.out_priority = 8'(r_rdata.prio);
                n_res.fill_level   = 5'(n_count);
                n_state            = S_RESULT;
            end

            S_RESULT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_idx <= n_idx;
        r_new <= n_new;
        r_res <= n_res;
        r_out <= n_out;
    end

endmodule

FILE: rtl/spq_checker.sv
// ============================================================================
// spq_checker
// Port-level checks on the queue's result channel, bound to the top level.
// ============================================================================
module spq_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input spq_pkg::t_out o_out_data
);
    import spq_pkg::*;

    // Waiting result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // Reported entry only with ok status
    a_entry_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.out_valid |-> o_out_data.status == ST_OK)
        else $error("entry reported with non-ok status");

    // No entry reported: payload fields are zero
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.out_valid |->
            o_out_data.out_tag == '0 && o_out_data.out_age == '0 &&
            o_out_data.out_priority == '0)
        else $error("nonzero payload without entry");

    // Empty status always reports an empty queue
    a_empty_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_EMPTY |->
            o_out_data.fill_level == '0 && !o_out_data.out_valid)
        else $error("empty status with entries held");

    // Reset drops any pending result
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind stable_priority_queue_top spq_checker u_spq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

FILE: tb/tb_stable_priority_queue_top.sv
// ============================================================================
// tb_stable_priority_queue_top
// Self-checking testbench for the stable sorted priority queue. A driver
// offers enqueue and dequeue requests from a backlog, and a shadow queue
// predicts each result when its request is accepted. A monitor compares
// every result field by field with the oldest prediction. Both channels
// idle at random, and one long output hold-off fills the block so that it
// stalls its input.
// ============================================================================
module tb_stable_priority_queue_top;

    import spq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int N_RANDOM    = 730;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 40;
    localparam int HOLD_CYCLES = 150;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid  = 1'b0;
    logic out_ready = 1'b0;
    t_in  in_data   = '0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    // Request backlog and predicted results
    t_in  request_backlog[$];
    t_out result_due_q[$];

    // Shadow copy of the queue contents
    logic [15:0] held_tag [DEPTH];
    logic [7:0]  held_age [DEPTH];
    logic [7:0]  held_prio[DEPTH];
    int          held_count = 0;

    int   tx_gap     = 0;
    int   rx_stall   = 0;
    int   n_accepted = 0;
    int   err_count  = 0;
    int   cycles     = 0;
    logic hold_off   = 1'b0;
    logic no_idle    = 1'b0;

    stable_priority_queue_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_data (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    task automatic add_req(input logic cmd, input logic [15:0] tag,
                           input logic [7:0] age, input logic [7:0] prio);
        t_in req;
        req.command        = cmd;
        req.entry_tag      = tag;
        req.entry_age      = age;
        req.entry_priority = prio;
        request_backlog.push_back(req);
    endtask

    // Apply one accepted request to the shadow queue and record its result
    task automatic apply_to_shadow_queue(input t_in req);
        t_out res;
        int   pos;
        res = '0;
        if (req.command == CMD_ENQ) begin
            if (held_count >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                // insert behind every entry with priority <= the new one
                pos = held_count;
                for (int i = 0; i < held_count; i++) begin
                    if (held_prio[i] > req.entry_priority) begin
                        pos = i;
                        break;
                    end
                end
                for (int i = held_count; i > pos; i--) begin
                    held_tag[i]  = held_tag[i-1];
                    held_age[i]  = held_age[i-1];
                    held_prio[i] = held_prio[i-1];
                end
                held_tag[pos]  = req.entry_tag;
                held_age[pos]  = req.entry_age;
                held_prio[pos] = req.entry_priority;
                held_count++;
                res.status = ST_OK;
            end
        end else begin
            if (held_count == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.status       = ST_OK;
                res.out_valid    = 1'b1;
                res.out_tag      = held_tag[0];
                res.out_age      = held_age[0];
                res.out_priority = held_prio[0];
                for (int i = 1; i < held_count; i++) begin
                    held_tag[i-1]  = held_tag[i];
                    held_age[i-1]  = held_age[i];
                    held_prio[i-1] = held_prio[i];
                end
                held_count--;
            end
        end
        res.fill_level = 5'(held_count);
        result_due_q.push_back(res);
    endtask

    // Compare one result with the oldest prediction
    task automatic check_result(input t_out got);
        t_out want;
        if (result_due_q.size() == 0) begin
            err_count++;
            if (err_count <= 10)
                $display("ERROR: unexpected result %h with nothing outstanding", got);
        end else begin
            want = result_due_q.pop_front();
            if (got.status !== want.status || got.out_valid !== want.out_valid ||
                got.out_tag !== want.out_tag || got.out_age !== want.out_age ||
                got.out_priority !== want.out_priority ||
                got.fill_level !== want.fill_level) begin
                err_count++;
                if (err_count <= 10) begin
                    $display("ERROR: result mismatch: expected st=%0d v=%0d tag=%h age=%h prio=%h fill=%0d",
                             want.status, want.out_valid, want.out_tag, want.out_age,
                             want.out_priority, want.fill_level);
                    $display("       got st=%0d v=%0d tag=%h age=%h prio=%h fill=%0d",
                             got.status, got.out_valid, got.out_tag, got.out_age,
                             got.out_priority, got.fill_level);
                end
            end
        end
    endtask

    // Directed requests: empty dequeue, field extremes, ties, full queue
    task automatic build_directed();
        logic [7:0] prios[16] = '{8'd255, 8'd0, 8'd7, 8'd7, 8'd0, 8'd255, 8'd128, 8'd7,
                                  8'd1, 8'd254, 8'd0, 8'd7, 8'd3, 8'd3, 8'd64, 8'd255};
        add_req(CMD_DEQ, 16'hFFFF, 8'hFF, 8'hFF);
        for (int i = 0; i < 16; i++)
            add_req(CMD_ENQ, (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : 16'(i * 16'h1111),
                    (i % 2 == 0) ? 8'h00 : 8'hFF, prios[i]);
        add_req(CMD_ENQ, 16'hA5A5, 8'h5A, 8'h00);
        for (int i = 0; i < 4; i++)
            add_req(CMD_DEQ, 16'h0000, 8'h00, 8'h00);
    endtask

    // Random phases that lean toward filling, draining or neither
    task automatic build_random();
        int n;
        int len;
        int enq_pct;
        int prio_mode;
        logic [7:0] prio;
        n = 0;
        while (n < N_RANDOM) begin
            len       = $urandom_range(10, 60);
            enq_pct   = ($urandom_range(0, 2) == 0) ? 85 :
                        ($urandom_range(0, 1) == 0) ? 20 : 55;
            prio_mode = $urandom_range(0, 2);
            for (int i = 0; i < len && n < N_RANDOM; i++) begin
                case (prio_mode)
                    0: prio = 8'($urandom_range(0, 3));
                    1: prio = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
                    default: prio = 8'($urandom);
                endcase
                if ($urandom_range(0, 9) == 0)
                    prio = 8'($urandom);
                add_req(($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ,
                        16'($urandom), 8'($urandom), prio);
                n++;
            end
        end
    endtask

    // Driver: offer backlog requests, predict on acceptance
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && o_in_ready) begin
                apply_to_shadow_queue(in_data);
                n_accepted <= n_accepted + 1;
                if ($urandom_range(0, 49) == 0)
                    no_idle <= ~no_idle;
            end
            if (!in_valid || o_in_ready) begin
                if (tx_gap != 0 && !hold_off) begin
                    tx_gap   <= tx_gap - 1;
                    in_valid <= 1'b0;
                end else if (request_backlog.size() != 0) begin
                    in_data  <= request_backlog.pop_front();
                    in_valid <= 1'b1;
                    tx_gap   <= hold_off ? 0 : pick_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check results, stall the output at random
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && out_ready)
                check_result(o_out_data);
            if (hold_off) begin
                out_ready <= 1'b0;
            end else if (rx_stall != 0) begin
                rx_stall  <= rx_stall - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (o_out_valid && out_ready)
                    rx_stall <= pick_gap();
            end
        end
    end

    // Long output hold-off so the block fills and blocks its input
    initial begin
        wait (n_accepted >= 300);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** stable_priority_queue_top: FAILED **");
            $finish;
        end
    end

    // Stimulus, reset and end of run
    initial begin
        build_directed();
        build_random();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (request_backlog.size() != 0 || in_valid || result_due_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0 && result_due_q.size() == 0)
            $display("** stable_priority_queue_top: PASSED **");
        else
            $display("** stable_priority_queue_top: FAILED **");
        $finish;
    end

endmodule

FILE: files.f
rtl/spq_pkg.sv
rtl/stable_priority_queue_top.sv
rtl/spq_checker.sv
tb/tb_stable_priority_queue_top.sv
